// File: hw/rtl/ecdf_pkg.sv
`timescale 1ns / 1ps

package ecdf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SIZE_WIDTH  = 32;

    localparam int PROB_W  = 17;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int SCAN_W  = ADDR_W + 1;
    localparam int PROD_W  = PROB_W + SIZE_WIDTH;
    localparam int STEP_W  = $clog2(PROD_W);

    localparam logic [SIZE_WIDTH-1:0] FALLBACK_RESET = SIZE_WIDTH'(50);

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int  CFG_IDX_W       = 1;
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_FALLBACK    = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic inexact;
    } div_status_t;

endpackage

// File: hw/rtl/ecdf_if.sv
`timescale 1ns / 1ps

interface ecdf_in_if import ecdf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [INDEX_W-1:0]    entry_index;
    logic [PROB_W-1:0]     entry_prob;
    logic [SIZE_WIDTH-1:0] entry_size;
    logic [PROB_W-1:0]     sample;

    modport source (output valid, opcode, entry_index, entry_prob, entry_size, sample,
                    input ready);
    modport sink   (input valid, opcode, entry_index, entry_prob, entry_size, sample,
                    output ready);
endinterface

interface ecdf_out_if import ecdf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SIZE_WIDTH-1:0] flow_size;
    logic                  in_table;

    modport source (output valid, flow_size, in_table, input ready);
    modport sink   (input valid, flow_size, in_table, output ready);
endinterface

// File: hw/rtl/empirical_cdf_flow_size_sampler_top.sv
`timescale 1ns / 1ps

// Flow size sampler over an empirical CDF table.
// Input channel in_ch: opcode 0 writes one (probability, size) point at
// entry_index; opcode 1 draws a size for the Q1.16 value in sample.
// Output channel out_ch: one transfer per sample item (flow_size, in_table),
// none for load items. Configuration: cfg_we/cfg_index/cfg_wdata write
// entry_count (index 0) or fallback_size (index 1).
// A sample item walks the table one entry per cycle from index 0 through a
// registered table memory read, then runs a restoring division for the
// interpolation when entry k covers the sample and interpolation is needed;
// a miss over the n entries in use ends the walk without a division. One
// item is in work at a time, and the next input transfer is taken once the
// result sits in the output register.
// Reset clears control state and sets entry_count to 0 and fallback_size to
// 50; the table contents stay undefined until written. When the receiver
// stalls, the result holds in the output register and a further sample
// waits at its final step until that register frees up.

module empirical_cdf_flow_size_sampler_top
    import ecdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ecdf_in_if.sink               in_ch,
    ecdf_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_WIDTH-1:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [COUNT_W-1:0]    entry_count_reg;
    logic [SIZE_WIDTH-1:0] fallback_reg;

    logic [SCAN_W-1:0]     idx_reg, idx_next;
    logic [SCAN_W-1:0]     limit_reg, limit_next;
    logic                  miss_reg, miss_next;
    logic                  use_prev_reg, use_prev_next;
    logic [PROB_W-1:0]     sample_reg, sample_next;
    logic [PROB_W-1:0]     prev_prob_reg, prev_prob_next;
    logic [SIZE_WIDTH-1:0] prev_size_reg, prev_size_next;
    logic [PROB_W-1:0]     a_reg, a_next;
    logic [PROB_W-1:0]     den_reg, den_next;
    logic [SIZE_WIDTH-1:0] d_reg, d_next;
    logic                  neg_reg, neg_next;
    logic                  trivial_reg, trivial_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SIZE_WIDTH-1:0] out_size_reg, out_size_next;
    logic                  out_hit_reg, out_hit_next;

    logic                  in_xfer;
    logic [31:0]           idx_wide;
    logic                  mem_we;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [PROB_W-1:0]     rd_prob;
    logic [SIZE_WIDTH-1:0] rd_size;
    logic                  div_start;
    logic [PROD_W-1:0]     div_quot;
    div_status_t           div_stat;

    logic [SCAN_W-1:0]     count_limit;
    logic [SCAN_W-1:0]     idx_inc;
    logic [PROB_W-1:0]     den_raw;
    logic [PROB_W-1:0]     a_raw;
    logic [SIZE_WIDTH-1:0] q_trunc;
    logic [SIZE_WIDTH-1:0] step_up;
    logic [SIZE_WIDTH-1:0] interp;
    logic [SIZE_WIDTH-1:0] size_sel;
    logic                  out_free;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign idx_wide = 32'(in_ch.entry_index);
    assign mem_we   = in_xfer && (in_ch.opcode == OP_LOAD) && (idx_wide < TABLE_DEPTH);
    assign out_free = !out_valid_reg || out_ch.ready;

    assign count_limit = (32'(entry_count_reg) > TABLE_DEPTH) ? SCAN_W'(TABLE_DEPTH)
                                                             : SCAN_W'(entry_count_reg);
    assign idx_inc = idx_reg + SCAN_W'(1);
    assign den_raw = rd_prob - prev_prob_reg;
    assign a_raw   = sample_reg - prev_prob_reg;

    assign q_trunc  = div_quot[SIZE_WIDTH-1:0];
    assign step_up  = q_trunc + SIZE_WIDTH'(div_stat.inexact);
    assign interp   = neg_reg ? (prev_size_reg - step_up) : (prev_size_reg + q_trunc);
    assign size_sel = miss_reg ? '0 : (use_prev_reg ? prev_size_reg : interp);

    assign div_start = (state_reg == ST_MUL) && !trivial_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            fallback_reg    <= FALLBACK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_FALLBACK:    fallback_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        miss_next      = miss_reg;
        use_prev_next  = use_prev_reg;
        sample_next    = sample_reg;
        prev_prob_next = prev_prob_reg;
        prev_size_next = prev_size_reg;
        a_next         = a_reg;
        den_next       = den_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        trivial_next   = trivial_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_size_next  = out_size_reg;
        out_hit_next   = out_hit_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (in_ch.opcode == OP_SAMPLE))
                begin
                    sample_next    = in_ch.sample;
                    prev_prob_next = '0;
                    prev_size_next = '0;
                    idx_next       = '0;
                    limit_next     = count_limit;
                    use_prev_next  = 1'b0;
                    if (count_limit == '0)
                    begin
                        miss_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        miss_next  = 1'b0;
                        rd_en      = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sample_reg <= rd_prob)
                begin
                    trivial_next = (rd_prob <= prev_prob_reg) || (sample_reg < prev_prob_reg);
                    den_next     = den_raw;
                    a_next       = (a_raw > den_raw) ? den_raw : a_raw;
                    neg_next     = rd_size < prev_size_reg;
                    d_next       = (rd_size < prev_size_reg) ? (prev_size_reg - rd_size)
                                                             : (rd_size - prev_size_reg);
                    state_next   = ST_MUL;
                end
                else
                begin
                    prev_prob_next = rd_prob;
                    prev_size_next = rd_size;
                    idx_next       = idx_inc;
                    if (idx_inc == limit_reg)
                    begin
                        miss_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[ADDR_W-1:0];
                    end
                end
            end
            ST_MUL:
            begin
                if (trivial_reg)
                begin
                    use_prev_next = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (size_sel == '0)
                    begin
                        out_size_next = fallback_reg;
                        out_hit_next  = 1'b0;
                    end
                    else
                    begin
                        out_size_next = size_sel;
                        out_hit_next  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        miss_reg      <= miss_next;
        use_prev_reg  <= use_prev_next;
        sample_reg    <= sample_next;
        prev_prob_reg <= prev_prob_next;
        prev_size_reg <= prev_size_next;
        a_reg         <= a_next;
        den_reg       <= den_next;
        d_reg         <= d_next;
        neg_reg       <= neg_next;
        trivial_reg   <= trivial_next;
        out_size_reg  <= out_size_next;
        out_hit_reg   <= out_hit_next;
    end

    ecdf_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (idx_wide[ADDR_W-1:0]),
        .wr_prob (in_ch.entry_prob),
        .wr_size (in_ch.entry_size),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_prob (rd_prob),
        .rd_size (rd_size)
    );

    // a * |d| goes straight into the divider's dividend register
    ecdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (PROD_W'(a_reg) * PROD_W'(d_reg)),
        .divisor  (den_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.flow_size = out_size_reg;
    assign out_ch.in_table  = out_hit_reg;

    // a new result only comes from the final step
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result appeared outside final step");

    // the walk never reads past the entries in use
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg < limit_reg)
        else $error("table walk past entry limit");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide step");

    // a covered sample never reports a zero size
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> out_size_reg != '0)
        else $error("in_table result with zero size");

endmodule

// File: hw/rtl/ecdf_mem.sv
`timescale 1ns / 1ps

module ecdf_mem
    import ecdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [PROB_W-1:0]     wr_prob,
    input  logic [SIZE_WIDTH-1:0] wr_size,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [PROB_W-1:0]     rd_prob,
    output logic [SIZE_WIDTH-1:0] rd_size
);

    logic [PROB_W-1:0]     prob_mem [TABLE_DEPTH];
    logic [SIZE_WIDTH-1:0] size_mem [TABLE_DEPTH];
    logic [PROB_W-1:0]     rd_prob_reg;
    logic [SIZE_WIDTH-1:0] rd_size_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prob_mem[wr_addr] <= wr_prob;
            size_mem[wr_addr] <= wr_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_prob_reg <= prob_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    assign rd_prob = rd_prob_reg;
    assign rd_size = rd_size_reg;

endmodule

// File: hw/rtl/ecdf_div.sv
`timescale 1ns / 1ps

module ecdf_div
    import ecdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PROB_W-1:0] divisor,
    output logic [PROD_W-1:0] quotient,
    output div_status_t       status
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] dvd_reg, dvd_next;
    logic [PROB_W-1:0] rem_reg, rem_next;
    logic [PROB_W-1:0] dsr_reg, dsr_next;
    logic [PROB_W:0]   shifted;
    logic [PROB_W:0]   diff;
    logic              fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[PROD_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[PROD_W-2:0], fits};
            rem_next = fits ? diff[PROB_W-1:0] : shifted[PROB_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient       = dvd_reg;
    assign status.done    = done_reg;
    assign status.inexact = |rem_reg;

endmodule

// File: tb/tb_empirical_cdf_flow_size_sampler_top.sv
`timescale 1ns / 1ps

module tb_empirical_cdf_flow_size_sampler_top
    import ecdf_pkg::*;
();

    localparam int DRAIN_CYCLES = 4 + TABLE_DEPTH + 49 + 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int N_DIRECTED   = 28;

    typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [SIZE_WIDTH-1:0] flow_size;
        logic                  in_table;
    } draw_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [INDEX_W-1:0]    index;
        logic [PROB_W-1:0]     value17;
        logic [SIZE_WIDTH-1:0] value32;
        bit                    typed;
        logic [SIZE_WIDTH-1:0] exp_size;
        logic                  exp_in;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SIZE_WIDTH-1:0] cfg_wdata;

    ecdf_in_if  in_ch ();
    ecdf_out_if out_ch ();

    empirical_cdf_flow_size_sampler_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [PROB_W-1:0]     cdf_prob [TABLE_DEPTH];
    logic [SIZE_WIDTH-1:0] cdf_size [TABLE_DEPTH];
    logic [COUNT_W-1:0]    cdf_count;
    logic [SIZE_WIDTH-1:0] cdf_fallback;

    draw_t pending_draws [$];
    int    mismatches = 0;
    int    items_done;
    bit    send_idle;
    bit    recv_idle;
    int    recv_hold = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 0,      0,            1, FALLBACK_RESET, 0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 65536,  0,            1, FALLBACK_RESET, 0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 131071, 0,            1, FALLBACK_RESET, 0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 0, 16384,  1000,         0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 1, 32768,  3000,         0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 2, 32768,  500,          0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 3, 49152,  100,          0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 4, 65536,  32'hFFFFFFFF, 0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 5, 65536,  0,            0, 0,              0},
        '{ROW_CFG,    REG_ENTRY_COUNT, 0, 0,      6,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 0,      0,            1, FALLBACK_RESET, 0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 1,      0,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 16384,  0,            1, 1000,           1},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 24576,  0,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 32768,  0,            1, 3000,           1},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 40000,  0,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 65536,  0,            1, 32'hFFFFFFFF,   1},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 65537,  0,            1, FALLBACK_RESET, 0},
        '{ROW_CFG,    REG_FALLBACK,    0, 0,      32'hFFFFFFFF, 0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 131071, 0,            1, 32'hFFFFFFFF,   0},
        // entry 0 at probability zero: empty interval at the origin
        '{ROW_LOAD,   REG_ENTRY_COUNT, 0, 0,      777,          0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 0,      0,            1, 32'hFFFFFFFF,   0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 100,    0,            0, 0,              0},
        '{ROW_CFG,    REG_FALLBACK,    0, 0,      0,            0, 0,              0},
        '{ROW_LOAD,   REG_ENTRY_COUNT, 4, 65536,  0,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 65536,  0,            0, 0,              0},
        '{ROW_SAMPLE, REG_ENTRY_COUNT, 0, 65537,  0,            1, 0,              0},
        '{ROW_CFG,    REG_ENTRY_COUNT, 0, 0,      1,            0, 0,              0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic int idle_len(bit enabled);
        int r;
        if (!enabled)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic draw_t draw_flow_size(logic [PROB_W-1:0] s);
        draw_t           res;
        longint unsigned pp;
        longint unsigned ps;
        longint unsigned cp;
        longint unsigned cs;
        longint unsigned a;
        longint unsigned den;
        longint unsigned sz;
        int              n;
        bit              hit;
        n   = (cdf_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cdf_count);
        hit = 1'b0;
        sz  = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && s <= cdf_prob[i])
            begin
                hit = 1'b1;
                pp  = (i > 0) ? cdf_prob[i-1] : 0;
                ps  = (i > 0) ? cdf_size[i-1] : 0;
                cp  = cdf_prob[i];
                cs  = cdf_size[i];
                if (cp <= pp || s < pp)
                begin
                    sz = ps;
                end
                else
                begin
                    den = cp - pp;
                    a   = s - pp;
                    if (a > den)
                    begin
                        a = den;
                    end
                    if (cs >= ps)
                    begin
                        sz = ps + a * (cs - ps) / den;
                    end
                    else
                    begin
                        sz = ps - (a * (ps - cs) + den - 1) / den;
                    end
                end
            end
        end
        if (hit && sz != 0)
        begin
            res.flow_size = sz[SIZE_WIDTH-1:0];
            res.in_table  = 1'b1;
        end
        else
        begin
            res.flow_size = cdf_fallback;
            res.in_table  = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_item(logic op, logic [INDEX_W-1:0] idx, logic [PROB_W-1:0] prob,
                             logic [SIZE_WIDTH-1:0] size, logic [PROB_W-1:0] smp,
                             bit typed, draw_t want);
        int gap;
        gap = idle_len(send_idle);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.entry_index <= idx;
        in_ch.entry_prob  <= prob;
        in_ch.entry_size  <= size;
        in_ch.sample      <= smp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_done++;
        if (op == OP_LOAD)
        begin
            cdf_prob[idx] = prob;
            cdf_size[idx] = size;
        end
        else
        begin
            pending_draws.insert(pending_draws.size(), typed ? want : draw_flow_size(smp));
        end
    endtask

    // idle the input side until every draw is back and the block is quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_draws.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [SIZE_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_ENTRY_COUNT)
        begin
            cdf_count = data[COUNT_W-1:0];
        end
        else
        begin
            cdf_fallback = data;
        end
        @(posedge clk);
    endtask

    // loads a non-decreasing cdf into entries 0..n-1
    task automatic build_table(int n);
        int                    p;
        int                    mode;
        logic [SIZE_WIDTH-1:0] sz;
        draw_t                 none;
        p    = 0;
        mode = $urandom_range(0, 2);
        sz   = $urandom_range(0, 100);
        none = '0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                p += $urandom_range(1, 2 * 65536 / n);
            end
            if (p > 65536 || (i == n - 1 && $urandom_range(0, 1) == 1))
            begin
                p = 65536;
            end
            case (mode)
                0:       sz = sz + $urandom_range(0, 5000);
                1:       sz = $urandom();
                default: sz = $urandom_range(0, 3);
            endcase
            send_item(OP_LOAD, INDEX_W'(i), PROB_W'(p), sz, PROB_W'($urandom()), 1'b0, none);
        end
    endtask

    task automatic random_phase();
        int                    n_eff;
        int                    r;
        int                    k;
        int                    cnt;
        logic [SIZE_WIDTH-1:0] fb;
        logic [PROB_W-1:0]     smp;
        draw_t                 none;
        none = '0;
        settle();
        case ($urandom_range(0, 9))
            0:       cnt = 0;
            1:       cnt = 1;
            2:       cnt = TABLE_DEPTH;
            3:       cnt = $urandom_range(TABLE_DEPTH + 1, 127);
            default: cnt = $urandom_range(2, TABLE_DEPTH);
        endcase
        case ($urandom_range(0, 5))
            0:       fb = '0;
            1:       fb = '1;
            2:       fb = FALLBACK_RESET;
            default: fb = $urandom();
        endcase
        write_reg(REG_ENTRY_COUNT, SIZE_WIDTH'(cnt));
        write_reg(REG_FALLBACK, fb);
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
        n_eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
        if (n_eff > 0 && $urandom_range(0, 9) < 7)
        begin
            build_table(n_eff);
        end
        repeat ($urandom_range(15, 60))
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_item(OP_LOAD, INDEX_W'($urandom()), PROB_W'($urandom()), $urandom(),
                          PROB_W'($urandom()), 1'b0, none);
            end
            else
            begin
                if (r < 60 || n_eff == 0)
                begin
                    smp = PROB_W'($urandom_range(0, 65536));
                end
                else if (r < 90)
                begin
                    k   = $urandom_range(0, n_eff - 1);
                    smp = PROB_W'(cdf_prob[k] + $urandom_range(0, 2) - 1);
                end
                else
                begin
                    smp = PROB_W'($urandom());
                end
                send_item(OP_SAMPLE, INDEX_W'($urandom()), PROB_W'($urandom()), $urandom(),
                          smp, 1'b0, none);
            end
        end
    endtask

    // result side: random stalls and in-order compare of each transfer
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_draws.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer flow_size=%0h in_table=%0b",
                                          out_ch.flow_size, out_ch.in_table));
            end
            else
            begin
                want = pending_draws.pop_front();
                if (out_ch.flow_size !== want.flow_size)
                begin
                    report_mismatch($sformatf("flow_size %0h, expected %0h",
                                              out_ch.flow_size, want.flow_size));
                end
                if (out_ch.in_table !== want.in_table)
                begin
                    report_mismatch($sformatf("in_table %0b, expected %0b",
                                              out_ch.in_table, want.in_table));
                end
            end
        end
        if (recv_hold > 0)
        begin
            recv_hold     = recv_hold - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_hold     = idle_len(recv_idle);
        end
    end

    initial
    begin
        int    random_base;
        draw_t want;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.entry_prob  <= '0;
        in_ch.entry_size  <= '0;
        in_ch.sample      <= '0;
        cdf_count    = '0;
        cdf_fallback = FALLBACK_RESET;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        items_done   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            want.flow_size = directed_rows[i].exp_size;
            want.in_table  = directed_rows[i].exp_in;
            case (directed_rows[i].kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(directed_rows[i].reg_sel, directed_rows[i].value32);
                end
                ROW_LOAD:
                begin
                    send_item(OP_LOAD, directed_rows[i].index, directed_rows[i].value17,
                              directed_rows[i].value32, PROB_W'($urandom()), 1'b0, want);
                end
                default:
                begin
                    send_item(OP_SAMPLE, INDEX_W'($urandom()), PROB_W'($urandom()),
                              $urandom(), directed_rows[i].value17,
                              directed_rows[i].typed, want);
                end
            endcase
        end

        // every entry gets written before any count can reach it
        settle();
        build_table(TABLE_DEPTH);
        random_base = items_done;
        while (items_done - random_base < RANDOM_ITEMS)
        begin
            random_phase();
        end
        settle();

        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
